// ===== src/cml_pkg.sv =====
// shared types, constants and fixed point helpers for the coupled map lattice oscillator
package cml_pkg;

  localparam int CELL_COUNT = 10;
  localparam int TAP_CELL   = 5;
  localparam int IDX_W      = $clog2(CELL_COUNT);

  localparam int Q_W       = 32;
  localparam int FRAC_W    = 28;
  localparam int WIDE_W    = 36;
  localparam int PERIOD_W  = 40;
  localparam int COUNT_W   = 41;
  localparam int OP_W      = 1;
  localparam int CIDX_W    = 4;

  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 2;

  localparam logic [OP_W-1:0] OP_TICK = 1'b0;
  localparam logic [OP_W-1:0] OP_LOAD = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_STEP_PERIOD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_MAP_GAIN    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COUPLING    = 2'd2;

  localparam logic [PERIOD_W-1:0]    STEP_PERIOD_RST = 40'd256;
  localparam logic signed [Q_W-1:0]  MAP_GAIN_RST    = 32'sd469762048;
  localparam logic signed [Q_W-1:0]  COUPLING_RST    = 32'sd26843546;

  localparam logic [PERIOD_W-1:0]     TICK_STEP  = 40'd256;
  localparam logic signed [WIDE_W-1:0] Q_ONE     = 36'sd268435456;
  localparam logic signed [Q_W-1:0]   Q_MAX      = 32'sh7fffffff;
  localparam logic signed [Q_W-1:0]   Q_MIN      = 32'sh80000000;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELL_COUNT - 1);
  localparam logic [IDX_W-1:0] TAP_IDX  = IDX_W'(TAP_CELL % CELL_COUNT);

  typedef struct packed {
    logic [PERIOD_W-1:0]   step_period;
    logic signed [Q_W-1:0] map_gain;
    logic signed [Q_W-1:0] coupling;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_RD,
    ST_SQ,
    ST_GP,
    ST_FN,
    ST_GB,
    ST_WR,
    ST_TAP_RD,
    ST_OUT
  } state_t;

  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
    logic fits;
    fits = (v[WIDE_W-1:Q_W-1] == {(WIDE_W-Q_W+1){1'b0}}) ||
           (v[WIDE_W-1:Q_W-1] == {(WIDE_W-Q_W+1){1'b1}});
    if (fits) begin
      return v[Q_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return Q_MIN;
    end else begin
      return Q_MAX;
    end
  endfunction

endpackage

// ===== src/cml_in_if.sv =====
// input channel carrying tick and load transactions
interface cml_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [cml_pkg::OP_W-1:0]               operation;
  logic [cml_pkg::CIDX_W-1:0]             cell_index;
  logic signed [cml_pkg::Q_W-1:0]         cell_value;

  modport source (output valid, output operation, output cell_index, output cell_value,
                  input ready);
  modport sink (input valid, input operation, input cell_index, input cell_value,
                output ready);
endinterface

// ===== src/cml_out_if.sv =====
// output channel carrying sample transactions
interface cml_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [cml_pkg::Q_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// ===== src/cml_ram.sv =====
// generic single write port ram with registered read
module cml_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/cml_mul.sv =====
// registered q3.28 multiplier with floor shift and saturation
module cml_mul (
  input  logic                           clk,
  input  logic signed [cml_pkg::Q_W-1:0] a,
  input  logic signed [cml_pkg::Q_W-1:0] b,
  output logic signed [cml_pkg::Q_W-1:0] q
);

  logic signed [2*cml_pkg::Q_W-1:0]  prod;
  logic signed [cml_pkg::WIDE_W-1:0] hi;

  always_comb begin
    prod = a * b;
    hi   = prod[2*cml_pkg::Q_W-1:cml_pkg::FRAC_W];
  end

  always_ff @(posedge clk) begin
    q <= cml_pkg::sat_q(hi);
  end

endmodule

// ===== src/cml_cfg.sv =====
// apb register file for step period, map gain and coupling
module cml_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cml_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [cml_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [cml_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output cml_pkg::cfg_t                     cfg
);

  logic [cml_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[cml_pkg::APB_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_period <= cml_pkg::STEP_PERIOD_RST;
      cfg.map_gain    <= cml_pkg::MAP_GAIN_RST;
      cfg.coupling    <= cml_pkg::COUPLING_RST;
    end else if (wr_en) begin
      case (reg_idx)
        cml_pkg::REG_STEP_PERIOD: cfg.step_period <= pwdata[cml_pkg::PERIOD_W-1:0];
        cml_pkg::REG_MAP_GAIN:    cfg.map_gain    <= pwdata[cml_pkg::Q_W-1:0];
        cml_pkg::REG_COUPLING:    cfg.coupling    <= pwdata[cml_pkg::Q_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cml_pkg::REG_STEP_PERIOD: prdata = cml_pkg::APB_DATA_W'(cfg.step_period);
      cml_pkg::REG_MAP_GAIN:    prdata = cml_pkg::APB_DATA_W'(unsigned'(cfg.map_gain));
      cml_pkg::REG_COUPLING:    prdata = cml_pkg::APB_DATA_W'(unsigned'(cfg.coupling));
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== src/coupled_map_lattice_oscillator_unit.sv =====
// top level: lattice sequencer, cell memory, step counter and output register
// a load transaction writes its cell in the cycle it is accepted and gives no result
// a tick without lattice update: ST_TICK, ST_TAP_RD, ST_OUT (stalls while output full)
// a tick with update: a priming pass, then ST_RD to ST_WR per cell, using one shared
// multiplier for four products per cell and the single write port cell ram
// reset clears cells (valid bits), step counter and control; registers take their defaults
module coupled_map_lattice_oscillator_unit (
  input  logic                           clk,
  input  logic                           rst,
  cml_in_if.sink                         in_item,
  cml_out_if.source                      out_item,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cml_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cml_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cml_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  cml_pkg::cfg_t   cfg;
  cml_pkg::state_t state, state_next;

  logic [cml_pkg::COUNT_W-1:0]  step_counter;
  logic [cml_pkg::PERIOD_W-1:0] period_eff;
  logic                         step_due;
  logic                         upd;
  logic                         prime;
  logic [cml_pkg::IDX_W-1:0]    cell_idx;
  logic [cml_pkg::CELL_COUNT-1:0] cell_vld;
  logic                         rd_vld;

  logic signed [cml_pkg::Q_W-1:0] fcur;
  logic signed [cml_pkg::Q_W-1:0] fn_reg;
  logic signed [cml_pkg::Q_W-1:0] a_reg;
  logic signed [cml_pkg::Q_W-1:0] x0_new;
  logic signed [cml_pkg::Q_W-1:0] out_data;
  logic                           out_valid;

  logic                           in_acc;
  logic                           load_ok;
  logic                           ram_we;
  logic [cml_pkg::IDX_W-1:0]      ram_waddr;
  logic [cml_pkg::Q_W-1:0]        ram_wdata;
  logic                           ram_re;
  logic [cml_pkg::IDX_W-1:0]      ram_raddr;
  logic [cml_pkg::Q_W-1:0]        ram_rdata;

  logic signed [cml_pkg::Q_W-1:0]    mul_a, mul_b, mul_q;
  logic signed [cml_pkg::Q_W-1:0]    x_sel, rd_val, w_val, fn_val, new_val;
  logic signed [cml_pkg::WIDE_W-1:0] w_wide, fn_wide, sum_wide;
  logic                              out_load;

  cml_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cml_ram #(
    .WIDTH (cml_pkg::Q_W),
    .DEPTH (cml_pkg::CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  cml_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .q   (mul_q)
  );

  assign in_item.ready   = (state == cml_pkg::ST_IDLE);
  assign in_acc          = in_item.valid && in_item.ready;
  assign load_ok         = 32'(in_item.cell_index) < 32'(cml_pkg::CELL_COUNT);
  assign out_item.valid  = out_valid;
  assign out_item.sample = out_data;

  assign period_eff = (cfg.step_period < cml_pkg::TICK_STEP) ? cml_pkg::TICK_STEP
                                                             : cfg.step_period;
  assign step_due   = step_counter >= {1'b0, period_eff};

  always_comb begin
    rd_val   = rd_vld ? signed'(ram_rdata) : '0;
    x_sel    = (!prime && cell_idx == cml_pkg::LAST_IDX) ? x0_new : rd_val;
    w_wide   = cml_pkg::Q_ONE - cfg.coupling;
    w_val    = cml_pkg::sat_q(w_wide);
    fn_wide  = cml_pkg::Q_ONE - mul_q;
    fn_val   = cml_pkg::sat_q(fn_wide);
    sum_wide = a_reg + mul_q;
    new_val  = cml_pkg::sat_q(sum_wide);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cml_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = cell_idx;
    ram_wdata  = new_val;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    mul_a      = '0;
    mul_b      = '0;
    out_load   = 1'b0;
    case (state)
      cml_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_item.operation == cml_pkg::OP_LOAD) begin
            ram_we    = load_ok;
            ram_waddr = cml_pkg::IDX_W'(in_item.cell_index);
            ram_wdata = in_item.cell_value;
          end else begin
            state_next = cml_pkg::ST_TICK;
          end
        end
      end
      cml_pkg::ST_TICK: begin
        state_next = upd ? cml_pkg::ST_RD : cml_pkg::ST_TAP_RD;
      end
      cml_pkg::ST_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = (prime || cell_idx == cml_pkg::LAST_IDX) ? '0
                                                              : cell_idx + 1'b1;
        state_next = cml_pkg::ST_SQ;
      end
      cml_pkg::ST_SQ: begin
        mul_a      = x_sel;
        mul_b      = x_sel;
        state_next = cml_pkg::ST_GP;
      end
      cml_pkg::ST_GP: begin
        mul_a      = cfg.map_gain;
        mul_b      = mul_q;
        state_next = cml_pkg::ST_FN;
      end
      cml_pkg::ST_FN: begin
        mul_a      = w_val;
        mul_b      = fcur;
        state_next = prime ? cml_pkg::ST_RD : cml_pkg::ST_GB;
      end
      cml_pkg::ST_GB: begin
        mul_a      = cfg.coupling;
        mul_b      = fn_reg;
        state_next = cml_pkg::ST_WR;
      end
      cml_pkg::ST_WR: begin
        ram_we     = 1'b1;
        state_next = (cell_idx == cml_pkg::LAST_IDX) ? cml_pkg::ST_TAP_RD : cml_pkg::ST_RD;
      end
      cml_pkg::ST_TAP_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = cml_pkg::TAP_IDX;
        state_next = cml_pkg::ST_OUT;
      end
      cml_pkg::ST_OUT: begin
        if (!out_valid || out_item.ready) begin
          out_load   = 1'b1;
          state_next = cml_pkg::ST_IDLE;
        end
      end
      default: state_next = cml_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_counter <= '0;
      upd          <= 1'b0;
      prime        <= 1'b0;
      cell_idx     <= '0;
      cell_vld     <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (ram_we) begin
        cell_vld[ram_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_item.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        cml_pkg::ST_IDLE: begin
          if (in_acc && in_item.operation == cml_pkg::OP_TICK) begin
            upd <= step_due;
            if (step_due) begin
              step_counter <= step_counter - {1'b0, period_eff};
            end
          end
        end
        cml_pkg::ST_TICK: begin
          step_counter <= step_counter + {1'b0, cml_pkg::TICK_STEP};
          prime        <= 1'b1;
          cell_idx     <= '0;
        end
        cml_pkg::ST_FN: begin
          prime <= 1'b0;
        end
        cml_pkg::ST_WR: begin
          if (cell_idx != cml_pkg::LAST_IDX) begin
            cell_idx <= cell_idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_vld <= cell_vld[ram_raddr];
    end
    if (state == cml_pkg::ST_FN) begin
      fn_reg <= fn_val;
      if (prime) begin
        fcur <= fn_val;
      end
    end
    if (state == cml_pkg::ST_GB) begin
      a_reg <= mul_q;
    end
    if (state == cml_pkg::ST_WR) begin
      fcur <= fn_reg;
      if (cell_idx == '0) begin
        x0_new <= new_val;
      end
    end
    if (out_load) begin
      out_data <= rd_val;
    end
  end

  a_ram_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == cml_pkg::ST_WR) || (state == cml_pkg::ST_IDLE && in_acc))
    else $error("cell ram written outside update or load");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == cml_pkg::ST_WR |-> 32'(cell_idx) < 32'(cml_pkg::CELL_COUNT))
    else $error("cell index beyond ring");

  a_no_update_path: assert property (@(posedge clk) disable iff (rst)
    (state == cml_pkg::ST_TICK && !upd) |=> state == cml_pkg::ST_TAP_RD)
    else $error("tick without update entered the lattice sweep");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == cml_pkg::ST_OUT))
    else $error("sample presented without a finished tick");

  a_sweep_ends_tap: assert property (@(posedge clk) disable iff (rst)
    (state == cml_pkg::ST_WR && cell_idx == cml_pkg::LAST_IDX) |=>
      state == cml_pkg::ST_TAP_RD)
    else $error("lattice sweep did not end at the tap read");

endmodule

// ===== sim/testbench.sv =====
// testbench for the coupled map lattice oscillator: directed and random tick and load traffic
module testbench;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int QUIET_CYCLES = 80;
  localparam int HOLD_CYCLES  = 600;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 228;
  localparam logic signed [63:0] UNIT_Q = 64'sd268435456;
  localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
  localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

  typedef struct {
    logic [cml_pkg::OP_W-1:0]       op;
    logic [cml_pkg::CIDX_W-1:0]     idx;
    logic signed [cml_pkg::Q_W-1:0] value;
    bit                             drain;
  } lattice_cmd_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [cml_pkg::APB_ADDR_W-1:0] paddr;
  logic [cml_pkg::APB_DATA_W-1:0] pwdata;
  logic [cml_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  cml_in_if  in_bus();
  cml_out_if out_bus();

  coupled_map_lattice_oscillator_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_bus),
    .out_item (out_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  lattice_cmd_t pending_cmds[$];
  logic signed [cml_pkg::Q_W-1:0] samples_due[$];
  int open_cmds = 0;
  int samples_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;

  logic signed [cml_pkg::Q_W-1:0] lattice_cells [cml_pkg::CELL_COUNT] = '{default: '0};
  logic [cml_pkg::COUNT_W-1:0]    phase_acc = '0;
  logic [cml_pkg::PERIOD_W-1:0]   period_reg;
  logic signed [cml_pkg::Q_W-1:0] gain_reg;
  logic signed [cml_pkg::Q_W-1:0] coupling_reg;

  lattice_cmd_t offered;
  logic send_next;
  int send_gap = 0;
  int send_calm = 0;
  int stall_left = 0;
  int hold_left = 0;
  int recv_calm = 0;
  logic signed [cml_pkg::Q_W-1:0] want;

  function automatic logic signed [cml_pkg::Q_W-1:0] clamp_q(input logic signed [63:0] v);
    if (v > SAT_HI) return cml_pkg::Q_MAX;
    if (v < SAT_LO) return cml_pkg::Q_MIN;
    return v[cml_pkg::Q_W-1:0];
  endfunction

  function automatic logic signed [cml_pkg::Q_W-1:0] fix_mul(
    input logic signed [cml_pkg::Q_W-1:0] a,
    input logic signed [cml_pkg::Q_W-1:0] b);
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    wa = a;
    wb = b;
    return clamp_q((wa * wb) >>> cml_pkg::FRAC_W);
  endfunction

  function automatic logic signed [cml_pkg::Q_W-1:0] logistic_map(
    input logic signed [cml_pkg::Q_W-1:0] x);
    logic signed [cml_pkg::Q_W-1:0] sq;
    logic signed [63:0] pw;
    sq = fix_mul(x, x);
    pw = fix_mul(gain_reg, sq);
    return clamp_q(UNIT_Q - pw);
  endfunction

  // in place sweep: the last cell sees the new cell 0
  function automatic void sweep_lattice();
    logic signed [cml_pkg::Q_W-1:0] keep;
    logic signed [cml_pkg::Q_W-1:0] own;
    logic signed [cml_pkg::Q_W-1:0] nbr;
    logic signed [63:0] gw;
    logic signed [63:0] ow;
    logic signed [63:0] nw;
    gw = coupling_reg;
    keep = clamp_q(UNIT_Q - gw);
    for (int i = 0; i < cml_pkg::CELL_COUNT; i++) begin
      own = fix_mul(keep, logistic_map(lattice_cells[i]));
      nbr = fix_mul(coupling_reg,
                    logistic_map(lattice_cells[(i + 1) % cml_pkg::CELL_COUNT]));
      ow = own;
      nw = nbr;
      lattice_cells[i] = clamp_q(ow + nw);
    end
  endfunction

  function automatic void apply_cmd(input lattice_cmd_t c);
    logic [cml_pkg::COUNT_W-1:0] limit;
    if (c.op == cml_pkg::OP_LOAD) begin
      if (c.idx < cml_pkg::CELL_COUNT) lattice_cells[c.idx] = c.value;
    end else begin
      limit = (period_reg < cml_pkg::TICK_STEP) ? cml_pkg::COUNT_W'(cml_pkg::TICK_STEP)
                                                 : cml_pkg::COUNT_W'(period_reg);
      if (phase_acc >= limit) begin
        phase_acc = phase_acc - limit;
        sweep_lattice();
      end
      phase_acc = phase_acc + cml_pkg::COUNT_W'(cml_pkg::TICK_STEP);
      samples_due.push_back(lattice_cells[cml_pkg::TAP_CELL % cml_pkg::CELL_COUNT]);
    end
  endfunction

  function automatic int draw_wait(inout int calm_run);
    if (calm_run > 0) begin
      calm_run--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_run = $urandom_range(8, 40);
      return 0;
    end
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic logic signed [cml_pkg::Q_W-1:0] cell_start_value();
    return int'($urandom_range(0, 32'h20000000)) - 32'sh10000000;
  endfunction

  function automatic void post_cmd(input logic [cml_pkg::OP_W-1:0] op,
                                   input logic [cml_pkg::CIDX_W-1:0] idx,
                                   input logic signed [cml_pkg::Q_W-1:0] value,
                                   input bit drain);
    lattice_cmd_t c;
    c.op = op;
    c.idx = idx;
    c.value = value;
    c.drain = drain;
    pending_cmds.push_back(c);
    open_cmds++;
  endfunction

  task automatic write_reg(input logic [cml_pkg::REG_IDX_W-1:0] idx,
                           input logic [cml_pkg::APB_DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= cml_pkg::APB_ADDR_W'({idx, 3'b000});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      cml_pkg::REG_STEP_PERIOD: period_reg = value[cml_pkg::PERIOD_W-1:0];
      cml_pkg::REG_MAP_GAIN: gain_reg = value[cml_pkg::Q_W-1:0];
      cml_pkg::REG_COUPLING: coupling_reg = value[cml_pkg::Q_W-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_quiet();
    while (open_cmds > 0 || samples_due.size() > 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic pick_settings();
    logic [cml_pkg::APB_DATA_W-1:0] p;
    logic [cml_pkg::APB_DATA_W-1:0] r;
    logic [cml_pkg::APB_DATA_W-1:0] g;
    case ($urandom_range(0, 9))
      0: p = $urandom_range(0, 255);
      1: p = {24'd0, 8'($urandom), 32'($urandom)};
      default: p = $urandom_range(256, 1200);
    endcase
    if ($urandom_range(0, 5) == 0) r = {32'd0, 32'($urandom)};
    else r = $urandom_range(32'h16000000, 32'h20000000);
    if ($urandom_range(0, 5) == 0) g = {32'd0, 32'($urandom)};
    else g = $urandom_range(0, 32'h08000000);
    write_reg(cml_pkg::REG_STEP_PERIOD, p);
    write_reg(cml_pkg::REG_MAP_GAIN, r);
    write_reg(cml_pkg::REG_COUPLING, g);
  endtask

  task automatic fill_random(input int count);
    int made;
    int run;
    int kind;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        run = $urandom_range(1, 12);
        repeat (run) begin
          post_cmd(cml_pkg::OP_TICK, cml_pkg::CIDX_W'($urandom), $urandom,
                   $urandom_range(0, 199) == 0);
          made++;
        end
      end else if (kind < 9) begin
        run = $urandom_range(1, 4);
        repeat (run) begin
          post_cmd(cml_pkg::OP_LOAD,
                   cml_pkg::CIDX_W'($urandom_range(0, cml_pkg::CELL_COUNT - 1)),
                   cell_start_value(), 1'b0);
          made++;
        end
      end else if ($urandom_range(0, 1) == 0) begin
        // index past the ring, dropped by the block
        post_cmd(cml_pkg::OP_LOAD,
                 cml_pkg::CIDX_W'($urandom_range(cml_pkg::CELL_COUNT,
                                                 2**cml_pkg::CIDX_W - 1)),
                 $urandom, 1'b0);
      end else begin
        post_cmd(cml_pkg::OP_LOAD,
                 cml_pkg::CIDX_W'($urandom_range(0, cml_pkg::CELL_COUNT - 1)),
                 $urandom, 1'b0);
        made++;
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("coupled_map_lattice_oscillator_unit: mismatch");
      $finish;
    end
  end

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_bus.valid <= 1'b0;
      in_bus.operation <= cml_pkg::OP_TICK;
      in_bus.cell_index <= '0;
      in_bus.cell_value <= '0;
      send_gap = 0;
    end else begin
      send_next = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        apply_cmd(offered);
        open_cmds--;
        send_next = 1'b0;
        send_gap = draw_wait(send_calm);
      end
      if (!send_next) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_cmds.size() > 0 &&
                     !(pending_cmds[0].drain && samples_due.size() > 0)) begin
          offered = pending_cmds.pop_front();
          in_bus.operation <= offered.op;
          in_bus.cell_index <= offered.idx;
          in_bus.cell_value <= offered.value;
          send_next = 1'b1;
        end
      end
      in_bus.valid <= send_next;
    end
  end

  // receiver and sample check
  always @(posedge clk) begin
    if (rst) begin
      out_bus.ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        samples_seen++;
        if (samples_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("sample %0d with none pending", out_bus.sample);
        end else begin
          want = samples_due.pop_front();
          if (out_bus.sample !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("sample transaction %0d: expected %0d, got %0d", samples_seen, want,
                       out_bus.sample);
            end
          end
        end
        stall_left = draw_wait(recv_calm);
        if (samples_seen == 150 || samples_seen == 700) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    period_reg = cml_pkg::STEP_PERIOD_RST;
    gain_reg = cml_pkg::MAP_GAIN_RST;
    coupling_reg = cml_pkg::COUPLING_RST;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // default registers, cleared lattice, extreme cell values, dropped loads
    post_cmd(cml_pkg::OP_TICK, '0, '0, 1'b0);
    post_cmd(cml_pkg::OP_TICK, '1, '1, 1'b0);
    post_cmd(cml_pkg::OP_LOAD, cml_pkg::CIDX_W'(0), cml_pkg::Q_MAX, 1'b0);
    post_cmd(cml_pkg::OP_LOAD, cml_pkg::CIDX_W'(cml_pkg::CELL_COUNT - 1), cml_pkg::Q_MIN,
             1'b0);
    post_cmd(cml_pkg::OP_LOAD, cml_pkg::CIDX_W'(cml_pkg::TAP_CELL % cml_pkg::CELL_COUNT),
             32'sh10000000, 1'b0);
    post_cmd(cml_pkg::OP_LOAD, cml_pkg::CIDX_W'(1), -32'sd1, 1'b0);
    post_cmd(cml_pkg::OP_LOAD, cml_pkg::CIDX_W'(cml_pkg::CELL_COUNT), 32'sd123, 1'b0);
    post_cmd(cml_pkg::OP_LOAD, '1, 32'sh55555555, 1'b0);
    repeat (4) post_cmd(cml_pkg::OP_TICK, '0, '0, 1'b0);
    post_cmd(cml_pkg::OP_LOAD, cml_pkg::CIDX_W'(4), '0, 1'b0);
    post_cmd(cml_pkg::OP_LOAD, cml_pkg::CIDX_W'(cml_pkg::TAP_CELL % cml_pkg::CELL_COUNT),
             -32'sh10000000, 1'b0);
    repeat (2) post_cmd(cml_pkg::OP_TICK, '0, '0, 1'b0);
    wait_quiet();

    // period below one sample, gain and coupling at their extremes
    write_reg(cml_pkg::REG_STEP_PERIOD, 64'd0);
    write_reg(cml_pkg::REG_MAP_GAIN, {32'd0, cml_pkg::Q_MAX});
    write_reg(cml_pkg::REG_COUPLING, {32'd0, cml_pkg::Q_MIN});
    post_cmd(cml_pkg::OP_LOAD, cml_pkg::CIDX_W'(6), cml_pkg::Q_MAX, 1'b0);
    repeat (3) post_cmd(cml_pkg::OP_TICK, '0, '0, 1'b0);
    wait_quiet();

    write_reg(cml_pkg::REG_STEP_PERIOD, 64'd255);
    write_reg(cml_pkg::REG_MAP_GAIN, {32'd0, cml_pkg::Q_MIN});
    write_reg(cml_pkg::REG_COUPLING, {32'd0, cml_pkg::Q_MAX});
    repeat (3) post_cmd(cml_pkg::OP_TICK, '0, '0, 1'b0);
    wait_quiet();

    write_reg(cml_pkg::REG_STEP_PERIOD, {24'd0, 40'hFF_FFFF_FFFF});
    write_reg(cml_pkg::REG_MAP_GAIN, 64'd0);
    write_reg(cml_pkg::REG_COUPLING, 64'd0);
    repeat (2) post_cmd(cml_pkg::OP_TICK, '0, '0, 1'b0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_quiet();
      pick_settings();
      fill_random(PHASE_ITEMS);
      if (ph == 3) pending_cmds[pending_cmds.size() / 2].drain = 1'b1;
    end
    wait_quiet();

    if (mismatches == 0) begin
      $display("coupled_map_lattice_oscillator_unit: match");
    end else begin
      $display("coupled_map_lattice_oscillator_unit: mismatch");
    end
    $finish;
  end

endmodule
